### src/itdf_pkg.sv
`default_nettype none

package itdf_pkg;

  // Field geometry
  localparam int MAX_WIDTH     = 16;
  localparam int POS_W         = $clog2(MAX_WIDTH);
  localparam int CHAR_W        = 7;

  // Conversion
  localparam int VALUE_W       = 32;
  localparam int DIGITS        = 10;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int DIGIT_CNT_W   = 4;
  localparam int DABBLE_BITS   = 4;
  localparam int DABBLE_STAGES = VALUE_W / DABBLE_BITS;
  localparam int CMP_W         = ((POS_W > DIGIT_CNT_W) ? POS_W : DIGIT_CNT_W) + 1;

  // Configuration
  localparam int CFG_FW_W      = 5;
  localparam int CFG_MODE_W    = 2;
  localparam int CFG_DATA_W    = 5;
  localparam logic [CFG_FW_W-1:0]   RST_FIELD_WIDTH = 5'd12;
  localparam logic [CFG_MODE_W-1:0] RST_SIGN_MODE   = 2'd1;
  localparam logic [CFG_MODE_W-1:0] SIGN_UNSIGNED   = 2'd0;
  localparam int                    FORCE_PLUS_BIT  = 1;

  typedef enum logic {
    CFG_FIELD_WIDTH = 1'b0,
    CFG_SIGN_MODE   = 1'b1
  } cfg_index_e;

  // Characters
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

  typedef struct packed {
    logic [BCD_W-1:0]   bcd;
    logic [VALUE_W-1:0] bin;
    logic               neg;
    logic               plus;
    logic [POS_W-1:0]   slots;
  } conv_t;

  typedef struct packed {
    logic [BCD_W-1:0]       bcd;
    logic [DIGIT_CNT_W-1:0] nd;
    logic                   neg;
    logic                   plus;
    logic [POS_W-1:0]       slots;
    logic [POS_W-1:0]       pad;
    logic                   ovf;
  } lay_t;

  typedef struct packed {
    logic [MAX_WIDTH-1:0][CHAR_W-1:0] chars;
    logic [POS_W-1:0]                 slots;
    logic [POS_W-1:0]                 pad;
    logic                             ovf;
  } field_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              number_start;
    logic              overflow;
    logic              last;
  } out_t;

  // One shift-add-3 step: correct every BCD digit, then shift one binary bit in.
  function automatic conv_t dabble_step(input conv_t c);
    conv_t r;
    r = c;
    for (int d = 0; d < DIGITS; d++) begin
      if (r.bcd[4*d +: 4] >= 4'd5) begin
        r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {r.bcd, r.bin} << 1;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/integer_to_decimal_field.sv
// integer_to_decimal_field: 32-bit value to right-justified decimal text.
// Input stream (s_axis_*): one word per value, tdata[31:0] = value.
// Output stream (m_axis_*): one word per field character, left to right;
//   tdata[6:0] is the ASCII character, tuser[0] marks the first sign or digit,
//   tuser[1] flags a truncated run, tlast marks the closing zero character.
// Config channel (cfg_*): index 0 = field_width (2..16, clamped), index 1 =
//   sign_mode (0 unsigned, 1 minus only, 2/3 forced plus). Write only when idle.
// Pipeline: sign/magnitude stage, 8 shift-add-3 stages (4 bits each), digit
//   count and layout stage, character build stage, then a character buffer
//   that shifts one word per cycle into the output register while that register is empty or being accepted.
// Output: W words per value, W the clamped field width (2..16), all through
//   the single output port draining the character buffer; the value
//   stages keep accepting while the buffer drains until they fill.
// Reset: all valid bits clear, field_width = 12, sign_mode = 1.
// Stall: when m_axis_tready is low the output word holds, the buffer and
//   each full stage behind it hold, and s_axis_tready drops once they are full.
`default_nettype none

module integer_to_decimal_field (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // value stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [itdf_pkg::VALUE_W-1:0]      s_axis_tdata,   // [31:0] value
  // character stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [7:0]                             m_axis_tdata,   // [6:0] character, [7] zero
  output logic [1:0]                             m_axis_tuser,   // [0] number_start, [1] overflow
  output logic                                   m_axis_tlast,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire itdf_pkg::cfg_index_e              cfg_index_i,
  input  wire logic [itdf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import itdf_pkg::*;

  logic [CFG_FW_W-1:0]   field_width_q;
  logic [CFG_MODE_W-1:0] sign_mode_q;

  // stage links: conv[0] from the front stage, conv[DABBLE_STAGES] finished BCD
  logic  conv_valid [DABBLE_STAGES+1];
  logic  conv_ready [DABBLE_STAGES+1];
  conv_t conv_data  [DABBLE_STAGES+1];

  logic   lay_valid, lay_ready;
  lay_t   lay_data;
  logic   fld_valid, fld_ready;
  field_t fld_data;
  out_t   out_word;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q <= RST_FIELD_WIDTH;
      sign_mode_q   <= RST_SIGN_MODE;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FIELD_WIDTH: field_width_q <= cfg_data_i[CFG_FW_W-1:0];
        CFG_SIGN_MODE:   sign_mode_q   <= cfg_data_i[CFG_MODE_W-1:0];
        default: ;
      endcase
    end
  end

  itdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .value_i       (s_axis_tdata),
    .field_width_i (field_width_q),
    .sign_mode_i   (sign_mode_q),
    .valid_o       (conv_valid[0]),
    .ready_i       (conv_ready[0]),
    .data_o        (conv_data[0])
  );

  // binary to BCD, DABBLE_BITS bits per stage
  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    itdf_dabble u_dabble (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (conv_valid[g]),
      .ready_o (conv_ready[g]),
      .data_i  (conv_data[g]),
      .valid_o (conv_valid[g+1]),
      .ready_i (conv_ready[g+1]),
      .data_o  (conv_data[g+1])
    );
  end

  itdf_layout u_layout (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (conv_valid[DABBLE_STAGES]),
    .ready_o (conv_ready[DABBLE_STAGES]),
    .data_i  (conv_data[DABBLE_STAGES]),
    .valid_o (lay_valid),
    .ready_i (lay_ready),
    .data_o  (lay_data)
  );

  itdf_field u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lay_valid),
    .ready_o (lay_ready),
    .data_i  (lay_data),
    .valid_o (fld_valid),
    .ready_i (fld_ready),
    .data_o  (fld_data)
  );

  itdf_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (fld_valid),
    .ready_o     (fld_ready),
    .data_i      (fld_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_word)
  );

  assign m_axis_tdata = {1'b0, out_word.character};
  assign m_axis_tuser = {out_word.overflow, out_word.number_start};
  assign m_axis_tlast = out_word.last;

endmodule

`default_nettype wire

### src/itdf_front.sv
`default_nettype none

module itdf_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            valid_i,
  output logic                                 ready_o,
  input  wire logic [itdf_pkg::VALUE_W-1:0]    value_i,
  input  wire logic [itdf_pkg::CFG_FW_W-1:0]   field_width_i,
  input  wire logic [itdf_pkg::CFG_MODE_W-1:0] sign_mode_i,
  output logic                                 valid_o,
  input  wire logic                            ready_i,
  output itdf_pkg::conv_t                      data_o
);
  import itdf_pkg::*;

  logic  valid_q;
  conv_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Sign split, magnitude and clamped width
  always_comb begin
    data_d.bcd  = '0;
    data_d.neg  = (sign_mode_i != SIGN_UNSIGNED) && value_i[VALUE_W-1];
    data_d.plus = sign_mode_i[FORCE_PLUS_BIT] && !value_i[VALUE_W-1];
    data_d.bin  = data_d.neg ? (~value_i + VALUE_W'(1)) : value_i;
    if (field_width_i < CFG_FW_W'(2)) begin
      data_d.slots = POS_W'(1);
    end else if (int'(field_width_i) > MAX_WIDTH) begin
      data_d.slots = POS_W'(MAX_WIDTH - 1);
    end else begin
      data_d.slots = POS_W'(field_width_i - CFG_FW_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/itdf_dabble.sv
`default_nettype none

module itdf_dabble (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire itdf_pkg::conv_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output itdf_pkg::conv_t     data_o
);
  import itdf_pkg::*;

  logic  valid_q;
  conv_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d = data_i;
    for (int s = 0; s < DABBLE_BITS; s++) begin
      data_d = dabble_step(data_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/itdf_layout.sv
`default_nettype none

module itdf_layout (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire itdf_pkg::conv_t data_i,
  output logic                 valid_o,
  input  wire logic            ready_i,
  output itdf_pkg::lay_t       data_o
);
  import itdf_pkg::*;

  logic             valid_q;
  lay_t             data_d, data_q;
  logic [CMP_W-1:0] tlen, slots_ext;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    data_d.bcd   = data_i.bcd;
    data_d.neg   = data_i.neg;
    data_d.plus  = data_i.plus;
    data_d.slots = data_i.slots;
    // significant digit count, zero still shows one digit
    data_d.nd = DIGIT_CNT_W'(1);
    for (int d = 1; d < DIGITS; d++) begin
      if (data_i.bcd[4*d +: 4] != 4'd0) begin
        data_d.nd = DIGIT_CNT_W'(d + 1);
      end
    end
    tlen       = CMP_W'(data_d.nd) + CMP_W'(data_i.neg || data_i.plus);
    slots_ext  = CMP_W'(data_i.slots);
    data_d.ovf = tlen > slots_ext;
    data_d.pad = data_d.ovf ? '0 : POS_W'(slots_ext - tlen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/itdf_field.sv
`default_nettype none

module itdf_field (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  output logic                ready_o,
  input  wire itdf_pkg::lay_t data_i,
  output logic                valid_o,
  input  wire logic           ready_i,
  output itdf_pkg::field_t    data_o
);
  import itdf_pkg::*;

  logic   valid_q;
  field_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;

  // Each position looks at its distance from the right end of the text.
  always_comb begin
    data_d.slots = data_i.slots;
    data_d.pad   = data_i.pad;
    data_d.ovf   = data_i.ovf;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      int r;
      r = int'(data_i.slots) - 1 - i;
      if (i >= int'(data_i.slots)) begin
        data_d.chars[i] = CH_NUL;
      end else if (r < int'(data_i.nd)) begin
        data_d.chars[i] = CH_ZERO;
        for (int d = 0; d < DIGITS; d++) begin
          if (r == d) begin
            data_d.chars[i] = CH_ZERO + CHAR_W'(data_i.bcd[4*d +: 4]);
          end
        end
      end else if (r == int'(data_i.nd) && data_i.neg) begin
        data_d.chars[i] = CH_MINUS;
      end else if (r == int'(data_i.nd) && data_i.plus) begin
        data_d.chars[i] = CH_PLUS;
      end else begin
        data_d.chars[i] = CH_SPACE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

### src/itdf_emit.sv
`default_nettype none

module itdf_emit (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output logic                  ready_o,
  input  wire itdf_pkg::field_t data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output itdf_pkg::out_t        out_o
);
  import itdf_pkg::*;

  logic             busy_q;
  logic [POS_W-1:0] pos_q;
  field_t           buf_q;
  logic             out_valid_q;
  out_t             out_q;
  logic             take, done, load;

  // take: move the head character into the output register
  assign take    = busy_q && (!out_valid_q || out_ready_i);
  assign done    = take && (pos_q == buf_q.slots);
  assign ready_o = !busy_q || done;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        pos_q  <= '0;
      end else if (done) begin
        busy_q <= 1'b0;
      end else if (take) begin
        pos_q <= pos_q + POS_W'(1);
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= data_i;
    end else if (take) begin
      buf_q.chars <= {CH_NUL, buf_q.chars[MAX_WIDTH-1:1]};
    end
    if (take) begin
      out_q.character    <= buf_q.chars[0];
      out_q.number_start <= (pos_q == buf_q.pad) && (pos_q != buf_q.slots);
      out_q.overflow     <= buf_q.ovf;
      out_q.last         <= (pos_q == buf_q.slots);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q <= buf_q.slots)
    else $error("emit position past closing slot");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && pos_q == '0)
    else $error("field load did not restart emission");

  a_last_nul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> out_q.character == CH_NUL)
    else $error("closing word is not the zero character");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_q.last == $past(done))
    else $error("last flag out of step with run end");

endmodule

`default_nettype wire
